// File: rtl/core/lwi_pkg.sv
// Shared types and constants for the Langevin work integrator.
// State encoding, multiply schedule codes, config register indexes, saturation helper.
// No dependencies.
package lwi_pkg;

    localparam int MUL_W  = 33;
    localparam int PROD_W = 66;

    typedef logic signed [PROD_W-1:0] t_wide;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_WB,
        S_UPD,
        S_DIV,
        S_DONE
    } t_state;

    // multiply schedule, in issue order
    typedef enum logic [3:0] {
        M_VX_DT,
        M_VY_DT,
        M_KX_X,
        M_AL_Y,
        M_KY_Y,
        M_BE_X,
        M_FX_DT,
        M_FY_DT,
        M_G_NX,
        M_G_NY,
        M_BE_XM,
        M_AL_YM,
        M_A_VYM,
        M_B_VXM,
        M_S_DT,
        M_CNT_DT
    } t_mul_idx;

    localparam logic [2:0] CFG_ALPHA = 3'd0;
    localparam logic [2:0] CFG_BETA  = 3'd1;
    localparam logic [2:0] CFG_KX    = 3'd2;
    localparam logic [2:0] CFG_KY    = 3'd3;
    localparam logic [2:0] CFG_DT    = 3'd4;
    localparam logic [2:0] CFG_GAIN  = 3'd5;

    // noise gain reset value, given at 24 fraction bits
    localparam longint unsigned GAIN_RST_Q24 = 64'd750300;
    localparam int              GAIN_RST_FB  = 24;

    typedef struct packed {
        logic     accept;
        logic     load_start;
        logic     mul_issue;
        logic     mul_wb;
        t_mul_idx mul_idx;
        logic     update;
        logic     div_init;
        logic     div_step;
        logic     capture;
    } t_dp_cmd;

    function automatic logic signed [31:0] sat32(input t_wide v);
        logic signed [31:0] r;
        if (v > t_wide'(64'sh7FFFFFFF)) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -t_wide'(64'sh80000000)) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/langevin_work_integrator.sv
// Langevin work integrator top level: lwi_ctrl sequencer plus lwi_dp datapath.
// Depends on lwi_pkg, lwi_ctrl, lwi_dp.
//
// Start request: accept, then capture from S_DONE into the output register.
// Step request: 16 products on one shared 33x33 multiplier, each issued in S_MUL
// and written back in S_WB, an update step, a divider load plus a 1-bit-per-cycle
// restoring divider of 32 + FRAC_BITS steps, then a capture from S_DONE.
// Throughput: one request at a time; the next is taken the cycle after capture,
// while the previous result may still wait in the output register.
// Reset (synchronous, active low): config to defaults, trajectory state to zero.
module langevin_work_integrator #(
    parameter int FRAC_BITS  = 24,
    parameter int COUNT_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write port
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [31:0]           i_cfg_data,
    // request channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_operation,
    input  logic signed [31:0]    i_start_pos_x,
    input  logic signed [31:0]    i_start_pos_y,
    input  logic signed [31:0]    i_start_vel_x,
    input  logic signed [31:0]    i_start_vel_y,
    input  logic signed [31:0]    i_noise_x,
    input  logic signed [31:0]    i_noise_y,
    // result channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [31:0]    o_pos_x,
    output logic signed [31:0]    o_pos_y,
    output logic signed [31:0]    o_vel_x,
    output logic signed [31:0]    o_vel_y,
    output logic signed [31:0]    o_total_work,
    output logic signed [31:0]    o_work_rate,
    output logic [COUNT_BITS-1:0] o_step_count
);
    import lwi_pkg::*;

    t_dp_cmd cmd;

    // sequencer: handshakes, multiply schedule, divider step count
    lwi_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_cmd       (cmd)
    );

    // datapath: registers, multiplier, divider, result hold
    lwi_dp #(
        .FRAC_BITS  (FRAC_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_start_pos_x (i_start_pos_x),
        .i_start_pos_y (i_start_pos_y),
        .i_start_vel_x (i_start_vel_x),
        .i_start_vel_y (i_start_vel_y),
        .i_noise_x     (i_noise_x),
        .i_noise_y     (i_noise_y),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_vel_x       (o_vel_x),
        .o_vel_y       (o_vel_y),
        .o_total_work  (o_total_work),
        .o_work_rate   (o_work_rate),
        .o_step_count  (o_step_count)
    );
endmodule

// File: rtl/core/lwi_ctrl.sv
// Sequencer for the Langevin work integrator.
// Walks the multiply schedule, the update step and the divider; owns both handshakes.
// Depends on lwi_pkg.
module lwi_ctrl #(
    parameter int FRAC_BITS = 24
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_operation,
    output logic             o_stall,
    output logic             o_valid,
    input  logic             i_stall,
    output lwi_pkg::t_dp_cmd o_cmd
);
    import lwi_pkg::*;

    localparam int DIV_STEPS = 32 + FRAC_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    t_state         r_state, n_state;
    t_mul_idx       r_idx, n_idx;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic           r_out_valid, n_out_valid;
    t_dp_cmd        cmd;
    logic           out_free;

    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= M_VX_DT;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        cmd     = '0;
        cmd.mul_idx = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.accept = 1'b1;
                    if (!i_operation) begin
                        cmd.load_start = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_idx   = M_VX_DT;
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                cmd.mul_issue = 1'b1;
                n_state = S_WB;
            end
            S_WB: begin
                cmd.mul_wb = 1'b1;
                if (r_idx == M_G_NY) begin
                    n_state = S_UPD;
                end else if (r_idx == M_CNT_DT) begin
                    n_state = S_DIV;
                    n_cnt   = '0;
                end else begin
                    n_idx   = t_mul_idx'(r_idx + 4'd1);
                    n_state = S_MUL;
                end
            end
            S_UPD: begin
                cmd.update = 1'b1;
                n_idx   = M_BE_XM;
                n_state = S_MUL;
            end
            S_DIV: begin
                // first cycle loads the divider, the rest shift one bit each
                if (r_cnt == '0) begin
                    cmd.div_init = 1'b1;
                end
                cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.capture = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.capture) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_cmd   = cmd;

    a_start_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !i_operation) |=> (r_state == S_DONE))
        else $error("start request did not go straight to result");
    a_step_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_operation) |=> (r_state == S_MUL && r_idx == M_VX_DT))
        else $error("step request did not begin the multiply schedule");
    a_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result capture lost");
endmodule

// File: rtl/core/lwi_dp.sv
// Datapath for the Langevin work integrator: config, state, shared multiplier,
// restoring divider and result registers. Driven by lwi_ctrl commands.
// Depends on lwi_pkg.
module lwi_dp #(
    parameter int FRAC_BITS  = 24,
    parameter int COUNT_BITS = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  lwi_pkg::t_dp_cmd        i_cmd,
    input  logic                    i_cfg_we,
    input  logic [2:0]              i_cfg_idx,
    input  logic [31:0]             i_cfg_data,
    input  logic signed [31:0]      i_start_pos_x,
    input  logic signed [31:0]      i_start_pos_y,
    input  logic signed [31:0]      i_start_vel_x,
    input  logic signed [31:0]      i_start_vel_y,
    input  logic signed [31:0]      i_noise_x,
    input  logic signed [31:0]      i_noise_y,
    output logic signed [31:0]      o_pos_x,
    output logic signed [31:0]      o_pos_y,
    output logic signed [31:0]      o_vel_x,
    output logic signed [31:0]      o_vel_y,
    output logic signed [31:0]      o_total_work,
    output logic signed [31:0]      o_work_rate,
    output logic [COUNT_BITS-1:0]   o_step_count
);
    import lwi_pkg::*;

    localparam int DVW = 32 + FRAC_BITS;
    localparam logic signed [31:0] ONE_Q    = 32'(64'd1 << FRAC_BITS);
    localparam logic [30:0]        DT_RST   = 31'((64'd1 << FRAC_BITS) / 1000);
    localparam logic [30:0]        GAIN_RST =
        31'((GAIN_RST_Q24 << FRAC_BITS) >> GAIN_RST_FB);

    // config
    logic signed [31:0] r_alpha, r_beta, r_kx, r_ky;
    logic [30:0]        r_dt, r_gain;
    // trajectory state
    logic signed [31:0] r_px, r_py, r_vx, r_vy, r_work;
    logic [COUNT_BITS-1:0] r_count;
    // step scratch
    logic signed [31:0] r_nx, r_ny, r_fx, r_fy, r_a, r_b, r_s;
    logic signed [31:0] r_xm, r_ym, r_vxm, r_vym;
    t_wide              r_dx, r_dy, r_tx, r_ty, r_gx, r_gy, r_acc;
    t_wide              r_prod;
    logic [63:0]        r_den;
    // divider
    logic [64:0]        r_rem;
    logic [DVW-1:0]     r_dvd, r_quo;
    logic               r_neg, r_den_zero;
    // result
    logic signed [31:0] r_o_px, r_o_py, r_o_vx, r_o_vy, r_o_work, r_o_rate;
    logic [COUNT_BITS-1:0] r_o_count;

    logic signed [MUL_W-1:0] op_a, op_b;
    t_wide              p;
    logic signed [31:0] x1, y1, vx1, vy1;
    logic signed [32:0] sx, sy, svx, svy;
    logic [32:0]        wneg;
    logic [31:0]        wmag;
    logic [64:0]        trial;
    logic               qbit;
    logic signed [31:0] rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ONE_Q;
            r_beta  <= -ONE_Q;
            r_kx    <= ONE_Q;
            r_ky    <= ONE_Q;
            r_dt    <= DT_RST;
            r_gain  <= GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ALPHA: r_alpha <= i_cfg_data;
                CFG_BETA:  r_beta  <= i_cfg_data;
                CFG_KX:    r_kx    <= i_cfg_data;
                CFG_KY:    r_ky    <= i_cfg_data;
                CFG_DT:    r_dt    <= i_cfg_data[30:0];
                CFG_GAIN:  r_gain  <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (i_cmd.mul_idx)
            M_VX_DT:  begin op_a = {r_vx[31], r_vx};   op_b = {2'b00, r_dt};   end
            M_VY_DT:  begin op_a = {r_vy[31], r_vy};   op_b = {2'b00, r_dt};   end
            M_KX_X:   begin op_a = {r_kx[31], r_kx};   op_b = {r_px[31], r_px}; end
            M_AL_Y:   begin op_a = {r_alpha[31], r_alpha}; op_b = {r_py[31], r_py}; end
            M_KY_Y:   begin op_a = {r_ky[31], r_ky};   op_b = {r_py[31], r_py}; end
            M_BE_X:   begin op_a = {r_beta[31], r_beta}; op_b = {r_px[31], r_px}; end
            M_FX_DT:  begin op_a = {r_fx[31], r_fx};   op_b = {2'b00, r_dt};   end
            M_FY_DT:  begin op_a = {r_fy[31], r_fy};   op_b = {2'b00, r_dt};   end
            M_G_NX:   begin op_a = {2'b00, r_gain};    op_b = {r_nx[31], r_nx}; end
            M_G_NY:   begin op_a = {2'b00, r_gain};    op_b = {r_ny[31], r_ny}; end
            M_BE_XM:  begin op_a = {r_beta[31], r_beta}; op_b = {r_xm[31], r_xm}; end
            M_AL_YM:  begin op_a = {r_alpha[31], r_alpha}; op_b = {r_ym[31], r_ym}; end
            M_A_VYM:  begin op_a = {r_a[31], r_a};     op_b = {r_vym[31], r_vym}; end
            M_B_VXM:  begin op_a = {r_b[31], r_b};     op_b = {r_vxm[31], r_vxm}; end
            M_S_DT:   begin op_a = {r_s[31], r_s};     op_b = {2'b00, r_dt};   end
            M_CNT_DT: begin
                op_a = {{(MUL_W-COUNT_BITS){1'b0}}, r_count};
                op_b = {2'b00, r_dt};
            end
            default:  begin op_a = '0; op_b = '0; end
        endcase
    end

    // product scaled back to Q8.24, floor rounding
    assign p = r_prod >>> FRAC_BITS;

    // state update from the gathered products
    assign x1  = sat32(t_wide'(r_px) + r_dx);
    assign y1  = sat32(t_wide'(r_py) + r_dy);
    assign vx1 = sat32(t_wide'(r_vx) - r_dx - r_tx + r_gx);
    assign vy1 = sat32(t_wide'(r_vy) - r_dy - r_ty + r_gy);
    assign sx  = {x1[31], x1} + {r_px[31], r_px};
    assign sy  = {y1[31], y1} + {r_py[31], r_py};
    assign svx = {vx1[31], vx1} + {r_vx[31], r_vx};
    assign svy = {vy1[31], vy1} + {r_vy[31], r_vy};

    // divider helpers
    assign wneg  = -{r_work[31], r_work};
    assign wmag  = r_work[31] ? wneg[31:0] : r_work;
    assign trial = {r_rem[63:0], r_dvd[DVW-1]};
    assign qbit  = (trial >= {1'b0, r_den});

    always_comb begin
        if (r_neg) begin
            if (r_quo > DVW'(64'h80000000)) begin
                rate = 32'sh80000000;
            end else begin
                rate = -r_quo[31:0];
            end
        end else begin
            if (r_quo > DVW'(64'h7FFFFFFF)) begin
                rate = 32'sh7FFFFFFF;
            end else begin
                rate = r_quo[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px       <= '0;
            r_py       <= '0;
            r_vx       <= '0;
            r_vy       <= '0;
            r_work     <= '0;
            r_count    <= '0;
            r_den_zero <= 1'b1;
        end else begin
            if (i_cmd.load_start) begin
                r_px       <= i_start_pos_x;
                r_py       <= i_start_pos_y;
                r_vx       <= i_start_vel_x;
                r_vy       <= i_start_vel_y;
                r_work     <= '0;
                r_count    <= '0;
                r_den_zero <= 1'b1;
            end
            if (i_cmd.update) begin
                r_px <= x1;
                r_py <= y1;
                r_vx <= vx1;
                r_vy <= vy1;
            end
            if (i_cmd.mul_wb && i_cmd.mul_idx == M_S_DT) begin
                r_work <= sat32(t_wide'(r_work) - p);
                if (r_count != '1) begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.div_init) begin
                r_den_zero <= (r_den == '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_nx <= i_noise_x;
            r_ny <= i_noise_y;
        end
        if (i_cmd.mul_issue) begin
            r_prod <= t_wide'(op_a) * t_wide'(op_b);
        end
        if (i_cmd.mul_wb) begin
            case (i_cmd.mul_idx)
                M_VX_DT:  r_dx  <= p;
                M_VY_DT:  r_dy  <= p;
                M_KX_X:   r_acc <= p;
                M_AL_Y:   r_fx  <= sat32(r_acc + p);
                M_KY_Y:   r_acc <= p;
                M_BE_X:   r_fy  <= sat32(r_acc + p);
                M_FX_DT:  r_tx  <= p;
                M_FY_DT:  r_ty  <= p;
                M_G_NX:   r_gx  <= p;
                M_G_NY:   r_gy  <= p;
                M_BE_XM:  r_a   <= sat32(p);
                M_AL_YM:  r_b   <= sat32(p);
                M_A_VYM:  r_acc <= p;
                M_B_VXM:  r_s   <= sat32(r_acc + p);
                M_CNT_DT: r_den <= r_prod[63:0];
                default: ;
            endcase
        end
        if (i_cmd.update) begin
            r_xm  <= sx[32:1];
            r_ym  <= sy[32:1];
            r_vxm <= svx[32:1];
            r_vym <= svy[32:1];
        end
        if (i_cmd.div_init) begin
            r_neg <= r_work[31];
            r_rem <= '0;
            r_dvd <= {wmag, {FRAC_BITS{1'b0}}};
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= qbit ? (trial - {1'b0, r_den}) : trial;
            r_dvd <= {r_dvd[DVW-2:0], 1'b0};
            r_quo <= {r_quo[DVW-2:0], qbit};
        end
        if (i_cmd.capture) begin
            r_o_px    <= r_px;
            r_o_py    <= r_py;
            r_o_vx    <= r_vx;
            r_o_vy    <= r_vy;
            r_o_work  <= r_work;
            r_o_rate  <= r_den_zero ? 32'sd0 : rate;
            r_o_count <= r_count;
        end
    end

    assign o_pos_x      = r_o_px;
    assign o_pos_y      = r_o_py;
    assign o_vel_x      = r_o_vx;
    assign o_vel_y      = r_o_vy;
    assign o_total_work = r_o_work;
    assign o_work_rate  = r_o_rate;
    assign o_step_count = r_o_count;
endmodule

// File: tb/lwi_checker.sv
// Result checker for the Langevin work integrator: watches both channels,
// predicts each result with its own fixed-point model and compares it.
// Depends on lwi_pkg (config register indexes).
module lwi_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_req_valid,
    input  logic               i_req_stall,
    input  logic               i_operation,
    input  logic signed [31:0] i_start_pos_x,
    input  logic signed [31:0] i_start_pos_y,
    input  logic signed [31:0] i_start_vel_x,
    input  logic signed [31:0] i_start_vel_y,
    input  logic signed [31:0] i_noise_x,
    input  logic signed [31:0] i_noise_y,
    input  logic               i_res_valid,
    input  logic               i_res_stall,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic signed [31:0] i_total_work,
    input  logic signed [31:0] i_work_rate,
    input  logic [23:0]        i_step_count,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import lwi_pkg::*;

    localparam int FB = 24;
    localparam longint COUNT_MAX = (64'd1 << 24) - 1;

    typedef struct {
        logic signed [31:0] px, py, vx, vy, work, rate;
        logic [23:0]        count;
    } t_state_out;

    t_state_out expected_q[$];

    longint alpha, beta, kx, ky, dt, gain;
    longint px, py, vx, vy, work;
    longint count;

    function automatic longint sat(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Q8.24 product, floor rounding (>>> on signed is floor)
    function automatic longint qmul(input longint a, input longint b);
        return (a * b) >>> FB;
    endfunction

    function automatic longint work_rate_of(input longint w, input longint n,
                                            input longint step);
        longint unsigned den, mag, q;
        den = n * step;
        if (den == 0) return 0;
        mag = (w < 0) ? -w : w;
        q = (mag << FB) / den;
        if (w < 0) return (q > 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
        return (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
    endfunction

    task automatic predict_step(input logic op, input longint nx, input longint ny,
                                input longint sx, input longint sy,
                                input longint svx, input longint svy);
        longint x1, y1, fx, fy, vx1, vy1, xm, ym, vxm, vym, a, b, s, rate;
        t_state_out e;
        rate = 0;
        if (!op) begin
            px = sx; py = sy; vx = svx; vy = svy; work = 0; count = 0;
        end else begin
            x1 = sat(px + qmul(vx, dt));
            y1 = sat(py + qmul(vy, dt));
            fx = sat(qmul(kx, px) + qmul(alpha, py));
            fy = sat(qmul(ky, py) + qmul(beta, px));
            vx1 = sat(vx - qmul(vx, dt) - qmul(fx, dt) + qmul(gain, nx));
            vy1 = sat(vy - qmul(vy, dt) - qmul(fy, dt) + qmul(gain, ny));
            xm = (x1 + px) >>> 1;
            ym = (y1 + py) >>> 1;
            vxm = (vx1 + vx) >>> 1;
            vym = (vy1 + vy) >>> 1;
            a = sat(qmul(beta, xm));
            b = sat(qmul(alpha, ym));
            s = sat(qmul(a, vym) + qmul(b, vxm));
            work = sat(work - qmul(s, dt));
            px = x1; py = y1; vx = vx1; vy = vy1;
            if (count < COUNT_MAX) count++;
            rate = work_rate_of(work, count, dt);
        end
        e.px = px; e.py = py; e.vx = vx; e.vy = vy;
        e.work = work; e.rate = rate; e.count = count;
        expected_q.push_back(e);
    endtask

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_state_out e;
        if (!i_rst_n) begin
            alpha = 16777216; beta = -16777216; kx = 16777216; ky = 16777216;
            dt = 16777; gain = 750300;
            px = 0; py = 0; vx = 0; vy = 0; work = 0; count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ALPHA: alpha = $signed(i_cfg_data);
                    CFG_BETA:  beta = $signed(i_cfg_data);
                    CFG_KX:    kx = $signed(i_cfg_data);
                    CFG_KY:    ky = $signed(i_cfg_data);
                    CFG_DT:    dt = i_cfg_data[30:0];
                    CFG_GAIN:  gain = i_cfg_data[30:0];
                    default: ;
                endcase
            end
            if (i_req_valid && !i_req_stall)
                predict_step(i_operation, i_noise_x, i_noise_y, i_start_pos_x,
                             i_start_pos_y, i_start_vel_x, i_start_vel_y);
            if (i_res_valid && !i_res_stall) begin
                if (expected_q.size() == 0) begin
                    $display("unexpected result at %0t", $realtime);
                    o_fail_count++;
                end else begin
                    e = expected_q.pop_front();
                    if (i_pos_x !== e.px) report("pos_x", i_pos_x, e.px);
                    if (i_pos_y !== e.py) report("pos_y", i_pos_y, e.py);
                    if (i_vel_x !== e.vx) report("vel_x", i_vel_x, e.vx);
                    if (i_vel_y !== e.vy) report("vel_y", i_vel_y, e.vy);
                    if (i_total_work !== e.work) report("total_work", i_total_work, e.work);
                    if (i_work_rate !== e.rate) report("work_rate", i_work_rate, e.rate);
                    if (i_step_count !== e.count)
                        report("step_count", i_step_count, e.count);
                end
            end
        end
        o_pending = expected_q.size();
    end
endmodule

// File: tb/tb_top.sv
// Testbench top for the Langevin work integrator: clock, reset, config writes,
// request stimulus with random idling, and the verdict.
// Depends on lwi_pkg, langevin_work_integrator and lwi_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lwi_pkg::*;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;
    localparam int   SETTLE_CYCLES = 120;   // longer than a step request takes

    logic               clk, rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_idx;
    logic [31:0]        cfg_data;
    logic               req_valid, req_stall, op;
    logic signed [31:0] spx, spy, svx, svy, nx, ny;
    logic               res_valid, res_stall;
    logic signed [31:0] pos_x, pos_y, vel_x, vel_y, total_work, work_rate;
    logic [23:0]        step_count;
    int                 fail_count, pending;

    // idle / stall pacing: 0 = none, otherwise percent of cycles spent idle
    int  send_idle_pct, recv_idle_pct;
    bit  recv_hold;

    langevin_work_integrator DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_valid(req_valid), .o_stall(req_stall), .i_operation(op),
        .i_start_pos_x(spx), .i_start_pos_y(spy),
        .i_start_vel_x(svx), .i_start_vel_y(svy),
        .i_noise_x(nx), .i_noise_y(ny),
        .o_valid(res_valid), .i_stall(res_stall),
        .o_pos_x(pos_x), .o_pos_y(pos_y), .o_vel_x(vel_x), .o_vel_y(vel_y),
        .o_total_work(total_work), .o_work_rate(work_rate), .o_step_count(step_count)
    );

    lwi_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_req_valid(req_valid), .i_req_stall(req_stall), .i_operation(op),
        .i_start_pos_x(spx), .i_start_pos_y(spy),
        .i_start_vel_x(svx), .i_start_vel_y(svy),
        .i_noise_x(nx), .i_noise_y(ny),
        .i_res_valid(res_valid), .i_res_stall(res_stall),
        .i_pos_x(pos_x), .i_pos_y(pos_y), .i_vel_x(vel_x), .i_vel_y(vel_y),
        .i_total_work(total_work), .i_work_rate(work_rate), .i_step_count(step_count),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Result side: random stall at the falling edge, or a forced hold-off.
    initial begin
        res_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (recv_hold) res_stall <= 1'b1;
            else res_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Long receiver hold-off, counted here so the sender keeps pushing.
    task automatic hold_receiver(input int cycles);
        recv_hold = 1'b1;
        repeat (cycles) @(negedge clk);
        recv_hold = 1'b0;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Push one request; valid stays up after acceptance and is dropped by the
    // next idle cycle, the next request or wait_drained.
    task automatic send_request(input logic operation, input logic [31:0] a,
                                input logic [31:0] b, input logic [31:0] c,
                                input logic [31:0] d, input logic [31:0] e,
                                input logic [31:0] f);
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1; op <= operation;
        spx <= a; spy <= b; svx <= c; svy <= d; nx <= e; ny <= f;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Noise mostly uniform over -2.0 to 2.0 in Q8.24, sometimes any 32-bit value.
    function automatic logic [31:0] rand_noise();
        if ($urandom_range(9) == 0) return $urandom;
        return $signed($urandom_range(67108864)) - 33554432;
    endfunction

    // State value: mostly moderate, sometimes full range.
    function automatic logic [31:0] rand_state();
        if ($urandom_range(7) == 0) return $urandom;
        return $signed($urandom_range(134217728)) - 67108864;
    endfunction

    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++) begin
            if (i == 0 || $urandom_range(39) == 0)
                send_request(OP_START, rand_state(), rand_state(), rand_state(),
                             rand_state(), $urandom, $urandom);
            else
                send_request(OP_STEP, $urandom, $urandom, $urandom, $urandom,
                             rand_noise(), rand_noise());
        end
    endtask

    initial begin
        rst_n = 1'b0; cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
        req_valid = 1'b0; op = OP_START;
        spx = '0; spy = '0; svx = '0; svy = '0; nx = '0; ny = '0;
        send_idle_pct = 0; recv_idle_pct = 0; recv_hold = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Directed: extreme starts, steps with extreme noise.
        send_request(OP_STEP, 0, 0, 0, 0, 0, 0);          // step from reset state
        send_request(OP_START, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                     32'h80000000, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_request(OP_STEP, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000);
        send_request(OP_STEP, 0, 0, 0, 0, 32'h80000000, 32'h7FFFFFFF);
        send_request(OP_START, 32'h01000000, 32'hFF000000, 32'h00800000,
                     32'h00000000, 0, 0);
        for (int i = 0; i < 4; i++)
            send_request(OP_STEP, 0, 0, 0, 0, 32'h01000000, 32'hFF000000);
        send_request(OP_START, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                     32'h7FFFFFFF, 0, 0);
        send_request(OP_STEP, 0, 0, 0, 0, 0, 0);
        wait_drained();

        // Extreme register setting; zero time step; invalid index ignored.
        write_reg(CFG_ALPHA, 32'h7FFFFFFF);
        write_reg(CFG_BETA, 32'h80000000);
        write_reg(CFG_KX, 32'h80000000);
        write_reg(CFG_KY, 32'h7FFFFFFF);
        write_reg(CFG_DT, 32'hFFFFFFFF);
        write_reg(CFG_GAIN, 32'h7FFFFFFF);
        write_reg(3'd7, 32'h12345678);
        send_request(OP_START, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                     32'h80000000, 0, 0);
        send_request(OP_STEP, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_request(OP_STEP, 0, 0, 0, 0, 32'h80000000, 32'h80000000);
        wait_drained();
        write_reg(CFG_DT, 32'h0);
        write_reg(CFG_GAIN, 32'h0);
        send_request(OP_START, 32'h00100000, 32'h00200000, 32'h00300000,
                     32'h00400000, 0, 0);
        send_request(OP_STEP, 0, 0, 0, 0, 32'h01000000, 32'h01000000);
        wait_drained();

        // Phase 1: defaults, no idling at all, receiver held off a long time.
        write_reg(CFG_ALPHA, 32'h01000000);
        write_reg(CFG_BETA, 32'hFF000000);
        write_reg(CFG_KX, 32'h01000000);
        write_reg(CFG_KY, 32'h01000000);
        write_reg(CFG_DT, 32'd16777);
        write_reg(CFG_GAIN, 32'd750300);
        fork
            hold_receiver(600);
            random_phase(120);
        join
        wait_drained();   // sender pauses until every result is back

        // Phase 2: random couplings, both sides idling.
        send_idle_pct = 35; recv_idle_pct = 35;
        write_reg(CFG_ALPHA, $signed($urandom_range(67108864)) - 33554432);
        write_reg(CFG_BETA, $signed($urandom_range(67108864)) - 33554432);
        write_reg(CFG_KX, $urandom_range(33554432));
        write_reg(CFG_KY, $urandom_range(33554432));
        write_reg(CFG_DT, $urandom_range(1, 1677721));
        write_reg(CFG_GAIN, $urandom_range(16777216));
        random_phase(200);
        wait_drained();

        // Phase 3: fully random registers (any bit pattern).
        write_reg(CFG_ALPHA, $urandom);
        write_reg(CFG_BETA, $urandom);
        write_reg(CFG_KX, $urandom);
        write_reg(CFG_KY, $urandom);
        write_reg(CFG_DT, $urandom);
        write_reg(CFG_GAIN, $urandom);
        random_phase(200);
        wait_drained();

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end
endmodule
